[rtl/skein256_block_compress_assert.svh]
// Assertion macros shared by the skein256 block compression RTL.
`ifndef SKEIN256_BLOCK_COMPRESS_ASSERT_SVH
`define SKEIN256_BLOCK_COMPRESS_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset.
`define SKN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SKN_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SKN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`define SKN_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/skn_pkg.sv]
// Shared types, constants and helper functions for the skein256 compression block.
package skn_pkg;

  localparam int SKN_ROUNDS = 72;

  localparam logic [63:0] SKN_PARITY      = 64'h1BD11BDAA9FC1A22;
  localparam logic [63:0] SKN_BLOCK_BYTES = 64'd32;
  localparam int          SKN_FLAG_FIRST  = 62;
  localparam int          SKN_FLAG_FINAL  = 63;

  typedef logic [3:0][63:0] skn_word4_t;

  // Skein-256-256 IV, word 0 in the lowest slot
  localparam skn_word4_t SKN_IV = {
    64'h6A54E920FDE8DA69, 64'hB33BC3896656840F,
    64'h2FCA66479FA7D833, 64'hFC9DA860D048B449
  };

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_BLOCK = 2'd1,
    CMD_FINAL = 2'd2,
    CMD_NONE  = 2'd3
  } skn_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY,
    ST_INJ,
    ST_RND,
    ST_FIN,
    ST_DONE
  } skn_state_t;

  typedef struct packed {
    logic       ready;
    logic       accept;
    logic       start;
    logic       key_en;
    logic       inj;
    logic       rnd;
    logic       fin;
    logic       emit;
    logic [2:0] rnd_sel;
  } skn_ctl_t;

  localparam logic [5:0] SKN_ROT_A [8] = '{6'd5, 6'd36, 6'd13, 6'd58,
                                           6'd26, 6'd53, 6'd11, 6'd59};
  localparam logic [5:0] SKN_ROT_B [8] = '{6'd56, 6'd28, 6'd46, 6'd44,
                                           6'd20, 6'd35, 6'd42, 6'd50};

  function automatic logic [63:0] skn_rotl(input logic [63:0] x, input logic [5:0] n);
    logic [127:0] w;
    w = {x, x} << n;
    return w[127:64];
  endfunction

endpackage

[rtl/skn_round.sv]
// Shared Threefish-256 datapath unit: one MIX round or one subkey injection.
module skn_round
  import skn_pkg::*;
(
  input  skn_word4_t  x,
  input  skn_word4_t  sk,
  input  logic        inj,
  input  logic [2:0]  rnd_sel,
  output skn_word4_t  y
);

  logic [63:0] add0_a, add0_b, add2_a, add2_b;
  logic [63:0] sum0, sum2;
  logic [5:0]  ra, rb;

  assign ra = SKN_ROT_A[rnd_sel];
  assign rb = SKN_ROT_B[rnd_sel];

  // operand routing: odd rounds pair word 0 with 3 and word 2 with 1
  always_comb begin
    if (inj) begin
      add0_a = x[0];
      add0_b = sk[0];
      add2_a = x[2];
      add2_b = sk[2];
    end else if (rnd_sel[0]) begin
      add0_a = x[0];
      add0_b = x[3];
      add2_a = x[2];
      add2_b = x[1];
    end else begin
      add0_a = x[0];
      add0_b = x[1];
      add2_a = x[2];
      add2_b = x[3];
    end
  end

  assign sum0 = add0_a + add0_b;
  assign sum2 = add2_a + add2_b;

  always_comb begin
    y[0] = sum0;
    y[2] = sum2;
    if (inj) begin
      y[1] = x[1] + sk[1];
      y[3] = x[3] + sk[3];
    end else if (rnd_sel[0]) begin
      y[3] = skn_rotl(x[3], ra) ^ sum0;
      y[1] = skn_rotl(x[1], rb) ^ sum2;
    end else begin
      y[1] = skn_rotl(x[1], ra) ^ sum0;
      y[3] = skn_rotl(x[3], rb) ^ sum2;
    end
  end

endmodule

[rtl/skn_keysched.sv]
// Threefish-256 key schedule: rotating key and tweak words and the registered subkey.
module skn_keysched
  import skn_pkg::*;
#(
  parameter int ROUNDS = SKN_ROUNDS,
  parameter int SW     = $clog2(ROUNDS / 4 + 2)
) (
  input  logic          clk,
  input  skn_ctl_t      ctl,
  input  skn_word4_t    chain,
  input  logic [63:0]   tweak_low,
  input  logic [63:0]   tweak_high,
  input  logic [SW-1:0] s_cnt,
  output skn_word4_t    sk
);

  logic [4:0][63:0] k_r, k_nxt;
  logic [2:0][63:0] t_r, t_nxt;
  skn_word4_t       sk_r, sk_nxt;

  always_comb begin
    k_nxt = k_r;
    t_nxt = t_r;
    if (ctl.start) begin
      k_nxt[3:0] = chain;
      k_nxt[4]   = chain[0] ^ chain[1] ^ chain[2] ^ chain[3] ^ SKN_PARITY;
      t_nxt[0]   = tweak_low;
      t_nxt[1]   = tweak_high;
      t_nxt[2]   = tweak_low ^ tweak_high;
    end else if (ctl.inj) begin
      // advance the schedule by one subkey
      k_nxt = {k_r[0], k_r[4], k_r[3], k_r[2], k_r[1]};
      t_nxt = {t_r[0], t_r[2], t_r[1]};
    end
  end

  always_comb begin
    sk_nxt = sk_r;
    if (ctl.key_en) begin
      sk_nxt[0] = k_r[0];
      sk_nxt[1] = k_r[1] + t_r[0];
      sk_nxt[2] = k_r[2] + t_r[1];
      sk_nxt[3] = k_r[3] + 64'(s_cnt);
    end
  end

  always_ff @(posedge clk) begin
    k_r  <= k_nxt;
    t_r  <= t_nxt;
    sk_r <= sk_nxt;
  end

  assign sk = sk_r;

endmodule

[rtl/skn_ctrl.sv]
// Sequencer for the compression: round and injection counters and the control state machine.
module skn_ctrl
  import skn_pkg::*;
#(
  parameter int ROUNDS = SKN_ROUNDS,
  parameter int SW     = $clog2(ROUNDS / 4 + 2)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_cmd,
  input  logic          out_busy,
  output skn_ctl_t      ctl,
  output logic [SW-1:0] s_cnt
);

  localparam int DW = $clog2(ROUNDS + 1);

  skn_state_t    state_r, state_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic          last_rnd;
  logic          grp_end;

  assign last_rnd = (d_r == DW'(ROUNDS - 1));
  assign grp_end  = (d_r[1:0] == 2'd3);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_cmd == CMD_BLOCK) ? ST_KEY : ST_DONE;
        end
      end
      ST_KEY: state_nxt = ST_INJ;
      ST_INJ: begin
        state_nxt = (d_r == DW'(ROUNDS)) ? ST_FIN : ST_RND;
      end
      ST_RND: begin
        if (grp_end) begin
          state_nxt = ST_INJ;
        end else if (last_rnd) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl         = '0;
    ctl.rnd_sel = d_r[2:0];
    unique case (state_r)
      ST_IDLE: begin
        ctl.ready  = 1'b1;
        ctl.accept = in_valid;
        ctl.start  = in_valid && (in_cmd == CMD_BLOCK);
      end
      ST_KEY:  ctl.key_en = 1'b1;
      ST_INJ:  ctl.inj = 1'b1;
      ST_RND: begin
        ctl.rnd    = 1'b1;
        ctl.key_en = 1'b1;
      end
      ST_FIN:  ctl.fin = 1'b1;
      ST_DONE: ctl.emit = !out_busy;
      default: ctl = '0;
    endcase
  end

  always_comb begin
    d_nxt = d_r;
    s_nxt = s_r;
    if (ctl.start) begin
      d_nxt = '0;
      s_nxt = '0;
    end else begin
      if (ctl.rnd) begin
        d_nxt = d_r + 1'b1;
      end
      if (ctl.inj) begin
        s_nxt = s_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      d_r     <= '0;
      s_r     <= '0;
    end else begin
      state_r <= state_nxt;
      d_r     <= d_nxt;
      s_r     <= s_nxt;
    end
  end

  assign s_cnt = s_r;

endmodule

[rtl/skein256_block_compress.sv]
// Top level of the Skein-256 UBI block compression (Threefish-256) engine.
// Each accepted command word returns one result word holding the four chaining words
// and the byte position. Init, final-mark and unused commands pass straight to the done
// state and then to ready again. A block command runs on one shared adder/rotate unit
// that does either one MIX round or one subkey injection per cycle, with the next subkey
// prepared alongside the rounds; the input side is not ready again until the block is
// done. A new command is accepted while the previous result still waits in the output
// register. The engine then holds its own result, with the input side not ready, until
// that register is read.
`include "skein256_block_compress_assert.svh"

module skein256_block_compress
  import skn_pkg::*;
#(
  parameter int ROUNDS = SKN_ROUNDS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [319:0] in_tdata,   // word0, word1, word2, word3, tweak_high_init
  input  logic [1:0]   in_tuser,   // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [319:0] out_tdata   // chain0, chain1, chain2, chain3, position
);

  localparam int SW = $clog2(ROUNDS / 4 + 2);

  skn_ctl_t      ctl;
  logic [SW-1:0] s_cnt;
  logic          out_busy;

  skn_word4_t    chain_r, chain_nxt;
  logic [63:0]   tweak_low_r, tweak_low_nxt;
  logic [63:0]   tweak_high_r, tweak_high_nxt;
  skn_word4_t    x_r, x_nxt;
  skn_word4_t    msg_r, msg_nxt;
  skn_word4_t    sk;
  skn_word4_t    unit_y;
  skn_word4_t    in_msg;
  logic          out_valid_r, out_valid_nxt;
  logic [319:0]  out_data_r, out_data_nxt;

  assign in_msg   = in_tdata[255:0];
  assign out_busy = out_valid_r && !out_tready;

  skn_ctrl #(
    .ROUNDS (ROUNDS),
    .SW     (SW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_cmd   (in_tuser),
    .out_busy (out_busy),
    .ctl      (ctl),
    .s_cnt    (s_cnt)
  );

  skn_keysched #(
    .ROUNDS (ROUNDS),
    .SW     (SW)
  ) u_keysched (
    .clk        (clk),
    .ctl        (ctl),
    .chain      (chain_r),
    .tweak_low  (tweak_low_nxt),
    .tweak_high (tweak_high_r),
    .s_cnt      (s_cnt),
    .sk         (sk)
  );

  skn_round u_round (
    .x       (x_r),
    .sk      (sk),
    .inj     (ctl.inj),
    .rnd_sel (ctl.rnd_sel),
    .y       (unit_y)
  );

  assign in_tready = ctl.ready;

  always_comb begin
    chain_nxt      = chain_r;
    tweak_low_nxt  = tweak_low_r;
    tweak_high_nxt = tweak_high_r;
    if (ctl.accept) begin
      case (in_tuser)
        CMD_INIT: begin
          chain_nxt      = SKN_IV;
          tweak_low_nxt  = '0;
          tweak_high_nxt = in_tdata[319:256];
        end
        CMD_BLOCK: tweak_low_nxt = tweak_low_r + SKN_BLOCK_BYTES;
        CMD_FINAL: tweak_high_nxt[SKN_FLAG_FINAL] = 1'b1;
        default: ;
      endcase
    end else if (ctl.fin) begin
      // feed forward and drop the first-block flag
      chain_nxt = x_r ^ msg_r;
      tweak_high_nxt[SKN_FLAG_FIRST] = 1'b0;
    end
  end

  always_comb begin
    x_nxt   = x_r;
    msg_nxt = msg_r;
    if (ctl.start) begin
      x_nxt   = in_msg;
      msg_nxt = in_msg;
    end else if (ctl.inj || ctl.rnd) begin
      x_nxt = unit_y;
    end
  end

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (ctl.emit) begin
      out_data_nxt  = {tweak_low_r, chain_r[3], chain_r[2], chain_r[1], chain_r[0]};
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r      <= SKN_IV;
      tweak_low_r  <= '0;
      tweak_high_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      chain_r      <= chain_nxt;
      tweak_low_r  <= tweak_low_nxt;
      tweak_high_r <= tweak_high_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    msg_r      <= msg_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `SKN_ASSERT_NXT(a_busy_after_accept, clk, rst_n, ctl.accept, !in_tready,
    "input side still ready after taking a word")
  `SKN_ASSERT_IMP(a_emit_slot_free, clk, rst_n, ctl.emit, !(out_valid_r && !out_tready),
    "result loaded over an unread result")
  `SKN_ASSERT_IMP(a_one_step, clk, rst_n, 1'b1,
    $onehot0({ctl.accept, ctl.inj, ctl.rnd, ctl.fin, ctl.emit}),
    "more than one datapath step in a cycle")
  `SKN_ASSERT_NXT(a_fin_then_hold, clk, rst_n, ctl.fin, !in_tready && $stable(x_r),
    "engine released or state moved after feed-forward")

endmodule

[tb/tb.sv]
// Self-checking testbench for the Skein-256 Threefish block compression engine.
`timescale 1ns / 1ps

module tb;
  import skn_pkg::*;

  localparam int          CIPHER_ROUNDS = 72;
  localparam int          QUIET_LIMIT   = 2000;
  localparam int          DRAIN_CYCLES  = 200;
  localparam int          ITEM_TARGET   = 1350;
  localparam logic [63:0] KEY_PARITY    = 64'h1BD11BDAA9FC1A22;
  localparam logic [255:0] CHAIN_IV     = {64'h6A54E920FDE8DA69, 64'hB33BC3896656840F,
                                           64'h2FCA66479FA7D833, 64'hFC9DA860D048B449};
  localparam int ROT_A [8] = '{5, 36, 13, 58, 26, 53, 11, 59};
  localparam int ROT_B [8] = '{56, 28, 46, 44, 20, 35, 42, 50};

  // Tracks the chaining state and holds the chaining values still to come.
  class chain_tracker;
    logic [63:0]  chain [4];
    logic [63:0]  position;
    logic [63:0]  tweak_hi;
    logic [319:0] pending_chains [$];
    int           mismatches;
    int           checked;

    function new();
      for (int i = 0; i < 4; i++) chain[i] = CHAIN_IV[64*i +: 64];
      position   = '0;
      tweak_hi   = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function logic [63:0] rot_left(input logic [63:0] v, input int n);
      return (v << n) | (v >> (64 - n));
    endfunction

    function void encipher(input logic [63:0] msg [4]);
      logic [63:0] k [5];
      logic [63:0] t [3];
      logic [63:0] x [4];
      int          s;
      position = position + 64'd32;
      for (int i = 0; i < 4; i++) k[i] = chain[i];
      k[4] = k[0] ^ k[1] ^ k[2] ^ k[3] ^ KEY_PARITY;
      t[0] = position;
      t[1] = tweak_hi;
      t[2] = t[0] ^ t[1];
      x[0] = msg[0] + k[0];
      x[1] = msg[1] + k[1] + t[0];
      x[2] = msg[2] + k[2] + t[1];
      x[3] = msg[3] + k[3];
      for (int d = 0; d < CIPHER_ROUNDS; d++) begin
        if (d % 2 == 0) begin
          x[0] = x[0] + x[1]; x[1] = rot_left(x[1], ROT_A[d % 8]) ^ x[0];
          x[2] = x[2] + x[3]; x[3] = rot_left(x[3], ROT_B[d % 8]) ^ x[2];
        end else begin
          x[0] = x[0] + x[3]; x[3] = rot_left(x[3], ROT_A[d % 8]) ^ x[0];
          x[2] = x[2] + x[1]; x[1] = rot_left(x[1], ROT_B[d % 8]) ^ x[2];
        end
        // subkey injection after every fourth round
        if (d % 4 == 3) begin
          s = (d + 1) / 4;
          x[0] = x[0] + k[s % 5];
          x[1] = x[1] + k[(s + 1) % 5] + t[s % 3];
          x[2] = x[2] + k[(s + 2) % 5] + t[(s + 1) % 3];
          x[3] = x[3] + k[(s + 3) % 5] + 64'(s);
        end
      end
      for (int i = 0; i < 4; i++) chain[i] = x[i] ^ msg[i];
      tweak_hi[SKN_FLAG_FIRST] = 1'b0;
    endfunction

    function void note_command(input skn_cmd_t cmd, input logic [319:0] data);
      logic [63:0] msg [4];
      for (int i = 0; i < 4; i++) msg[i] = data[64*i +: 64];
      case (cmd)
        CMD_INIT: begin
          for (int i = 0; i < 4; i++) chain[i] = CHAIN_IV[64*i +: 64];
          position = '0;
          tweak_hi = data[256 +: 64];
        end
        CMD_BLOCK: encipher(msg);
        CMD_FINAL: tweak_hi[SKN_FLAG_FINAL] = 1'b1;
        default: ;
      endcase
      pending_chains.push_back({position, chain[3], chain[2], chain[1], chain[0]});
    endfunction

    function void check_chain(input logic [319:0] got);
      logic [319:0] want;
      string        names [5];
      names = '{"chain0", "chain1", "chain2", "chain3", "position"};
      checked++;
      if (pending_chains.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      want = pending_chains.pop_front();
      for (int f = 0; f < 5; f++) begin
        if (got[64*f +: 64] !== want[64*f +: 64]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch on %s (result %0d): expected %h got %h",
                     names[f], checked, want[64*f +: 64], got[64*f +: 64]);
        end
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [319:0] in_tdata;    // word0, word1, word2, word3, tweak_high_init
  logic [1:0]   in_tuser;    // cmd
  logic         out_tvalid;
  logic         out_tready;
  logic [319:0] out_tdata;   // chain0, chain1, chain2, chain3, position

  chain_tracker tracker;
  int           sent [4];
  int           sent_total;
  int           quiet;
  bit           tx_eager;
  bit           rx_eager;

  skein256_block_compress dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [255:0] rand_block();
    return {rand_word(), rand_word(), rand_word(), rand_word()};
  endfunction

  function automatic logic [63:0] first_tweak();
    return {1'b0, 1'b1, 6'($urandom_range(0, 63)), 56'd0};
  endfunction

  task automatic issue(input skn_cmd_t cmd, input logic [255:0] msg, input logic [63:0] th);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {th, msg};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_command(cmd, {th, msg});
    sent[int'(cmd)]++;
    sent_total++;
  endtask

  // Result side: random back-pressure with occasional eager stretches.
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 30) == 0) rx_eager = !rx_eager;
      stall = rx_eager ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      tracker.check_chain(out_tdata);
    end
  end

  // Abort when nothing moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int nblk;
    tracker    = new();
    sent       = '{0, 0, 0, 0};
    sent_total = 0;
    quiet      = 0;
    tx_eager   = 1'b0;
    rx_eager   = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= CMD_NONE;
    in_tdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: block straight after reset, unused command, extremes of the words
    issue(CMD_BLOCK, rand_block(), rand_word());
    issue(CMD_NONE, '0, '0);
    issue(CMD_INIT, '1, '0);
    issue(CMD_BLOCK, '0, '1);
    issue(CMD_BLOCK, '1, '0);
    issue(CMD_FINAL, '1, '1);
    issue(CMD_BLOCK, {4{64'hAAAA_AAAA_AAAA_AAAA}}, '0);
    issue(CMD_INIT, '0, '1);
    issue(CMD_NONE, '1, '1);
    issue(CMD_BLOCK, {4{64'h5555_5555_5555_5555}}, '1);
    issue(CMD_FINAL, '0, '0);
    issue(CMD_FINAL, rand_block(), rand_word());
    issue(CMD_BLOCK, rand_block(), rand_word());
    tx_eager = 1'b1;
    issue(CMD_INIT, rand_block(), 64'h7000_0000_0000_0000);
    issue(CMD_BLOCK, rand_block(), rand_word());
    issue(CMD_BLOCK, rand_block(), rand_word());
    issue(CMD_FINAL, rand_block(), rand_word());
    issue(CMD_BLOCK, rand_block(), rand_word());
    issue(CMD_INIT, '0, 64'hC000_0000_0000_0000);
    issue(CMD_BLOCK, '0, '0);

    // random: mostly init, blocks, final mark, last block; some loose commands
    while (sent_total < ITEM_TARGET) begin
      tx_eager = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) != 0) begin
        issue(CMD_INIT, rand_block(),
              ($urandom_range(0, 3) == 0) ? rand_word() : first_tweak());
        nblk = $urandom_range(0, 4);
        repeat (nblk) issue(CMD_BLOCK, rand_block(), rand_word());
        issue(CMD_FINAL, rand_block(), rand_word());
        issue(CMD_BLOCK, rand_block(), rand_word());
      end else begin
        nblk = $urandom_range(1, 4);
        repeat (nblk) issue(skn_cmd_t'($urandom_range(0, 3)), rand_block(), rand_word());
      end
    end
    in_tvalid <= 1'b0;

    // drain, then hold a while to catch stray results
    while (tracker.pending_chains.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Drove %0d init, %0d block, %0d final-mark and %0d unused commands",
             sent[int'(CMD_INIT)], sent[int'(CMD_BLOCK)], sent[int'(CMD_FINAL)],
             sent[int'(CMD_NONE)]);
    $display("Checked %0d result words, %0d mismatches, %0d still outstanding",
             tracker.checked, tracker.mismatches, tracker.pending_chains.size());
    if (tracker.mismatches == 0 && tracker.pending_chains.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
